### rtl/skc_pkg.sv
// ----------------------------------------------------------------------------
// skc_pkg
// Shared constants, types and coefficient helpers for the skin classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

    // default fractional bits of the fixed point coefficients
    localparam int COEF_FRAC_BITS_DEF = 14;

    // queue between front and back
    localparam int QUEUE_DEPTH = 8;

    // hue divider: quotient bits and dividend width (8-bit divisor)
    localparam int QUOT_W     = 10;
    localparam int DIVIDEND_W = 8 + QUOT_W;

    // hue in 1/16 degree
    localparam int HUE_W = 13;
    localparam logic [HUE_W-1:0] HUE_LOW_RST   = 13'd565;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST  = 13'd5195;
    localparam logic [HUE_W-1:0] HUE_SECT_SPAN = 13'd960;
    localparam logic [HUE_W-1:0] HUE_BASE_GRN  = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BASE_BLU  = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL      = 13'd5760;

    // configuration register indexes
    localparam logic CFG_HUE_LOW  = 1'b0;
    localparam logic CFG_HUE_HIGH = 1'b1;

    // hue sector, named after the largest component
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // round(m / 1000 * 2^f), half up
    function automatic longint fx_milli(input longint m, input int f);
        return ((m <<< f) + 500) / 1000;
    endfunction

    // round(t / 10000 * 2^f), half up
    function automatic longint fx_tenk(input longint t, input int f);
        return ((t <<< f) + 5000) / 10000;
    endfunction

    // one classified pixel, handed from front to back
    typedef struct packed {
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
        logic                  rgb_ok;
        logic                  ycc_ok;
        logic                  grey;
        logic                  hue_neg;
        logic [1:0]            sector;
        logic [DIVIDEND_W-1:0] dividend;
        logic [7:0]            divisor;
    } skc_item_t;

endpackage

`default_nettype wire

### rtl/skc_front.sv
// ----------------------------------------------------------------------------
// skc_front
// Three stage pipeline: RGB rule, BT.601 YCrCb bounds and hue divider setup.
// Never stalls; a credit count keeps the queue behind it from overflowing.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_front
    import skc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // blue [7:0], green [15:8], red [23:16]
    input  wire logic        q_pop,
    output logic             push_valid,
    output skc_item_t        push_item
);

    localparam int F      = COEF_FRAC_BITS;
    localparam int YSUM_W = F + 11;
    localparam int CHR_W  = F + 12;
    localparam int CMP_W  = F + 12;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // luma coefficients
    localparam logic [YSUM_W-1:0] C_YB  = YSUM_W'(fx_milli(114, F));
    localparam logic [YSUM_W-1:0] C_YG  = YSUM_W'(fx_milli(587, F));
    localparam logic [YSUM_W-1:0] C_YR  = YSUM_W'(fx_milli(299, F));
    localparam logic [YSUM_W-1:0] Y_RND = YSUM_W'(longint'(1) <<< (F - 1));

    // chroma coefficients and offset (128 plus rounding half)
    localparam logic signed [CHR_W-1:0] C_CR = CHR_W'(fx_milli(713, F));
    localparam logic signed [CHR_W-1:0] C_CB = CHR_W'(fx_milli(564, F));
    localparam logic signed [CHR_W-1:0] C_OFS =
        CHR_W'((longint'(128) <<< F) + (longint'(1) <<< (F - 1)));

    // cr against cb bounds
    localparam logic [CMP_W-1:0] K1 = CMP_W'(fx_tenk(15862, F));
    localparam logic [CMP_W-1:0] O1 = CMP_W'(fx_tenk(200000, F));
    localparam logic [CMP_W-1:0] K2 = CMP_W'(fx_tenk(3448, F));
    localparam logic [CMP_W-1:0] O2 = CMP_W'(fx_tenk(762069, F));
    localparam logic [CMP_W-1:0] K3 = CMP_W'(fx_tenk(45652, F));
    localparam logic [CMP_W-1:0] O3 = CMP_W'(fx_tenk(2345652, F));
    localparam logic [CMP_W-1:0] K4 = CMP_W'(fx_tenk(11500, F));
    localparam logic [CMP_W-1:0] O4 = CMP_W'(fx_tenk(3017500, F));
    localparam logic [CMP_W-1:0] K5 = CMP_W'(fx_tenk(22857, F));
    localparam logic [CMP_W-1:0] O5 = CMP_W'(fx_tenk(4328500, F));

    // rgb rule thresholds
    localparam logic [7:0] DAY_R_MIN   = 8'd95;
    localparam logic [7:0] DAY_G_MIN   = 8'd40;
    localparam logic [7:0] DAY_B_MIN   = 8'd20;
    localparam logic [7:0] SPREAD_MIN  = 8'd15;
    localparam logic [7:0] FLASH_R_MIN = 8'd220;
    localparam logic [7:0] FLASH_G_MIN = 8'd210;
    localparam logic [7:0] FLASH_B_MIN = 8'd170;

    logic [7:0] in_b, in_g, in_r;
    logic       accept;

    // credit count: items accepted and not yet popped from the queue
    logic [CNT_W-1:0] used_reg, used_next;

    // stage 1
    logic             v1_reg;
    logic [7:0]       s1_b_reg, s1_g_reg, s1_r_reg;
    logic [8:0]       s1_y_reg;
    logic             s1_rgb_reg, s1_grey_reg, s1_neg_reg;
    logic [1:0]       s1_sect_reg;
    logic [7:0]       s1_mag_reg, s1_d_reg;

    // stage 2
    logic             v2_reg;
    logic [7:0]       s2_b_reg, s2_g_reg, s2_r_reg;
    logic [7:0]       s2_cr_reg, s2_cb_reg;
    logic             s2_rgb_reg, s2_grey_reg, s2_neg_reg;
    logic [1:0]       s2_sect_reg;
    logic [DIVIDEND_W-1:0] s2_dvd_reg;
    logic [7:0]       s2_d_reg;

    // stage 3
    logic             v3_reg;
    skc_item_t        s3_item_reg;

    assign in_b   = s_tdata[7:0];
    assign in_g   = s_tdata[15:8];
    assign in_r   = s_tdata[23:16];
    assign accept = s_tvalid & s_tready;

    // credit tracking
    assign s_tready = (used_reg < CNT_W'(QUEUE_DEPTH));

    always_comb begin
        used_next = used_reg;
        if (accept && !q_pop) begin
            used_next = used_reg + 1'b1;
        end else if (!accept && q_pop) begin
            used_next = used_reg - 1'b1;
        end
    end

    // stage 1 logic: luma, rgb rule, hue sector
    logic [7:0]        mx, mn, spread, rg_abs, hop_a, hop_b;
    logic [1:0]        sect;
    logic              day, flash;
    logic [YSUM_W-1:0] ysum;

    always_comb begin
        mx     = (in_r > in_g) ? ((in_r > in_b) ? in_r : in_b)
                               : ((in_g > in_b) ? in_g : in_b);
        mn     = (in_r < in_g) ? ((in_r < in_b) ? in_r : in_b)
                               : ((in_g < in_b) ? in_g : in_b);
        spread = mx - mn;
        rg_abs = (in_r > in_g) ? (in_r - in_g) : (in_g - in_r);
        day    = (in_r > DAY_R_MIN) && (in_g > DAY_G_MIN) && (in_b > DAY_B_MIN) &&
                 (spread > SPREAD_MIN) && (rg_abs > SPREAD_MIN) &&
                 (in_r > in_g) && (in_r > in_b);
        flash  = (in_r > FLASH_R_MIN) && (in_g > FLASH_G_MIN) &&
                 (in_b > FLASH_B_MIN) && (rg_abs <= SPREAD_MIN) &&
                 (in_r > in_b) && (in_g > in_b);
        ysum   = YSUM_W'(in_b) * C_YB + YSUM_W'(in_g) * C_YG +
                 YSUM_W'(in_r) * C_YR + Y_RND;
        // red wins ties, then green
        if (mx == in_r) begin
            sect  = SECT_RED;
            hop_a = in_g;
            hop_b = in_b;
        end else if (mx == in_g) begin
            sect  = SECT_GREEN;
            hop_a = in_b;
            hop_b = in_r;
        end else begin
            sect  = SECT_BLUE;
            hop_a = in_r;
            hop_b = in_g;
        end
    end

    // stage 2 logic: chroma with saturation, divider operands
    logic signed [9:0]       dr, db;
    logic signed [CHR_W-1:0] cr_full, cb_full, cr_sh, cb_sh;
    logic [7:0]              cr_sat, cb_sat;
    logic [DIVIDEND_W-1:0]   dvd;

    always_comb begin
        dr      = $signed({2'b00, s1_r_reg}) - $signed({1'b0, s1_y_reg});
        db      = $signed({2'b00, s1_b_reg}) - $signed({1'b0, s1_y_reg});
        cr_full = CHR_W'(dr) * C_CR + C_OFS;
        cb_full = CHR_W'(db) * C_CB + C_OFS;
        cr_sh   = cr_full >>> F;
        cb_sh   = cb_full >>> F;
        if (cr_sh < 0) begin
            cr_sat = 8'd0;
        end else if (cr_sh > 255) begin
            cr_sat = 8'hff;
        end else begin
            cr_sat = cr_sh[7:0];
        end
        if (cb_sh < 0) begin
            cb_sat = 8'd0;
        end else if (cb_sh > 255) begin
            cb_sat = 8'hff;
        end else begin
            cb_sat = cb_sh[7:0];
        end
        // rounded quotient: (960*|diff| + d/2) / d
        dvd = DIVIDEND_W'(s1_mag_reg) * DIVIDEND_W'(HUE_SECT_SPAN) +
              DIVIDEND_W'(s1_d_reg >> 1);
    end

    // stage 3 logic: five linear bounds
    logic [CMP_W-1:0] crs, cbw;
    logic             ycc_ok;

    always_comb begin
        crs    = CMP_W'(s2_cr_reg) << F;
        cbw    = CMP_W'(s2_cb_reg);
        ycc_ok = (crs <= K1 * cbw + O1) &&
                 (crs >= K2 * cbw + O2) &&
                 (crs + K3 * cbw >= O3) &&
                 (crs + K4 * cbw <= O4) &&
                 (crs + K5 * cbw <= O5);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end else begin
            used_reg <= used_next;
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_b_reg    <= in_b;
        s1_g_reg    <= in_g;
        s1_r_reg    <= in_r;
        s1_y_reg    <= ysum[F +: 9];
        s1_rgb_reg  <= day | flash;
        s1_grey_reg <= (spread == 8'd0);
        s1_neg_reg  <= (hop_a < hop_b);
        s1_mag_reg  <= (hop_a < hop_b) ? (hop_b - hop_a) : (hop_a - hop_b);
        s1_d_reg    <= spread;
        s1_sect_reg <= sect;

        s2_b_reg    <= s1_b_reg;
        s2_g_reg    <= s1_g_reg;
        s2_r_reg    <= s1_r_reg;
        s2_cr_reg   <= cr_sat;
        s2_cb_reg   <= cb_sat;
        s2_rgb_reg  <= s1_rgb_reg;
        s2_grey_reg <= s1_grey_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_sect_reg <= s1_sect_reg;
        s2_dvd_reg  <= dvd;
        s2_d_reg    <= s1_d_reg;

        s3_item_reg.blue     <= s2_b_reg;
        s3_item_reg.green    <= s2_g_reg;
        s3_item_reg.red      <= s2_r_reg;
        s3_item_reg.rgb_ok   <= s2_rgb_reg;
        s3_item_reg.ycc_ok   <= ycc_ok;
        s3_item_reg.grey     <= s2_grey_reg;
        s3_item_reg.hue_neg  <= s2_neg_reg;
        s3_item_reg.sector   <= s2_sect_reg;
        s3_item_reg.dividend <= s2_dvd_reg;
        s3_item_reg.divisor  <= s2_d_reg;
    end

    assign push_valid = v3_reg;
    assign push_item  = s3_item_reg;

endmodule

`default_nettype wire

### rtl/skc_queue.sv
// ----------------------------------------------------------------------------
// skc_queue
// Small FIFO between the classifying front and the hue/output back.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_queue
    import skc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    input  wire skc_item_t  push_item,
    input  wire logic       pop,
    output logic            head_valid,
    output skc_item_t       head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    skc_item_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers, wrap at the depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/skc_back.sv
// ----------------------------------------------------------------------------
// skc_back
// Pipelined hue divider (one quotient bit per stage), hue band test and
// output register. The whole pipeline holds while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_back
    import skc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        head_valid,
    input  wire skc_item_t   head_item,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    typedef struct packed {
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic              rgb_ok;
        logic              ycc_ok;
        logic              grey;
        logic              hue_neg;
        logic [1:0]        sector;
        logic [7:0]        rem;
        logic [QUOT_W-1:0] dq;
        logic [7:0]        divisor;
    } div_stage_t;

    // one restoring step: next quotient bit into dq, dividend bit out
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t n;
        logic [8:0] trial;
        logic       ge;
        n     = s;
        trial = {s.rem, s.dq[QUOT_W-1]};
        ge    = (trial >= {1'b0, s.divisor});
        n.rem = ge ? 8'(trial - {1'b0, s.divisor}) : trial[7:0];
        n.dq  = {s.dq[QUOT_W-2:0], ge};
        return n;
    endfunction

    logic [HUE_W-1:0] hue_low_reg, hue_high_reg;
    logic             adv;
    div_stage_t       load;
    div_stage_t       st_reg [QUOT_W];
    logic [QUOT_W-1:0] st_v_reg;
    logic             out_valid_reg;
    logic [23:0]      out_data_reg;
    logic             out_skin_reg;

    // limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_HUE_LOW:  hue_low_reg  <= cfg_wdata;
                CFG_HUE_HIGH: hue_high_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // pipeline moves when the output slot is free or being taken
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && head_valid;

    always_comb begin
        load.blue    = head_item.blue;
        load.green   = head_item.green;
        load.red     = head_item.red;
        load.rgb_ok  = head_item.rgb_ok;
        load.ycc_ok  = head_item.ycc_ok;
        load.grey    = head_item.grey;
        load.hue_neg = head_item.hue_neg;
        load.sector  = head_item.sector;
        load.rem     = head_item.dividend[DIVIDEND_W-1:QUOT_W];
        load.dq      = head_item.dividend[QUOT_W-1:0];
        load.divisor = head_item.divisor;
    end

    // hue from the last stage and the band test
    div_stage_t        fin;
    logic [HUE_W-1:0]  base;
    logic signed [HUE_W:0] hue_s;
    logic [HUE_W-1:0]  hue;
    logic              skin;

    always_comb begin
        fin = st_reg[QUOT_W-1];
        case (fin.sector)
            SECT_RED:   base = '0;
            SECT_GREEN: base = HUE_BASE_GRN;
            SECT_BLUE:  base = HUE_BASE_BLU;
            default:    base = '0;
        endcase
        if (fin.hue_neg) begin
            hue_s = $signed({1'b0, base}) - $signed({{(HUE_W + 1 - QUOT_W){1'b0}}, fin.dq});
        end else begin
            hue_s = $signed({1'b0, base}) + $signed({{(HUE_W + 1 - QUOT_W){1'b0}}, fin.dq});
        end
        if (hue_s < 0) begin
            hue_s = hue_s + $signed({1'b0, HUE_FULL});
        end
        // grey pixel has hue zero
        hue  = fin.grey ? '0 : hue_s[HUE_W-1:0];
        skin = fin.rgb_ok && fin.ycc_ok &&
               ((hue < hue_low_reg) || (hue > hue_high_reg));
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_v_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            st_v_reg      <= {st_v_reg[QUOT_W-2:0], head_valid};
            out_valid_reg <= st_v_reg[QUOT_W-1];
        end
    end

    // divider stages and output payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= div_step(load);
            for (int k = 1; k < QUOT_W; k++) begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
            out_data_reg <= skin ? {fin.red, fin.green, fin.blue} : 24'd0;
            out_skin_reg <= skin;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_skin_reg;

endmodule

`default_nettype wire

### rtl/rgb_ycrcb_hsv_skin_classifier_unit.sv
// ----------------------------------------------------------------------------
// rgb_ycrcb_hsv_skin_classifier_unit
// Rule based skin classifier: RGB rule, YCrCb bounds and hue band per pixel;
// skin pixels pass, others go out black, with a skin flag.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: blue, green, red (8 bit each)
//  m_axis    | out       | tdata: blue, green, red; tuser: skin flag
//  cfg       | in        | index 0 hue low limit, index 1 hue high limit
//
//  One pixel per clock sustained unless the output stalls, through 3 front stages,
//  the queue, 10 divider stages (one quotient bit each), the output register.
//  Reset is synchronous and active low; it empties the pipelines and loads
//  the hue limits with 565 and 5195.
//  An output stall holds the back pipeline; the front keeps running into an
//  8 entry queue and s_tready drops once the queue credits are used up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_ycrcb_hsv_skin_classifier_unit
    import skc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // in_blue [7:0], in_green [15:8], in_red [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // out_blue [7:0], out_green [15:8], out_red [23:16]
    output logic [0:0]       m_tuser,     // is_skin [0]
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_wdata
);

    logic      push_valid;
    skc_item_t push_item;
    logic      head_valid;
    skc_item_t head_item;
    logic      q_pop;

    // classification front
    skc_front #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_pop      (q_pop),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // decoupling queue
    skc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // hue and output back
    skc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/skc_checker.sv
// ----------------------------------------------------------------------------
// skc_checker
// Port level checks of the skin classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // non-skin pixels go out black
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("non-skin pixel not black");

    // both rgb rules need red above 95
    a_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[23:16] > 8'd95)
        else $error("skin flag with low red");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb_ycrcb_hsv_skin_classifier_unit skc_checker u_skc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
